// File: design/ptp_pkg.sv
// Shared constants and types for the point to triangle projection core.
// No dependencies; compiled first.
package ptp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 17;
  localparam logic [TolW-1:0] TolReset = 17'd655;

  // quotient bits produced by every divider
  localparam int unsigned QuoW   = 43;
  localparam int unsigned RsNumW = 96;
  localparam int unsigned RsDenW = 61;
  localparam int unsigned DpNumW = 62;
  localparam int unsigned DpDenW = 31;

  // r and s are signed, magnitude clamped to 2^40
  localparam int unsigned RsW = 42;
  localparam logic [RsW-2:0] RsLim = 41'h100_0000_0000;
  localparam logic signed [RsW+1:0] OneQ = 44'sd65536;

  typedef struct packed {
    logic                          degen;
    logic                          r_neg;
    logic                          s_neg;
    logic [RsNumW-1:0]             r_num;
    logic [RsNumW-1:0]             s_num;
    logic [RsDenW-1:0]             nn;
    logic [2:0]                    d_neg;
    logic [2:0][DpNumW-1:0]        d_num;
    logic [DpDenW-1:0]             m2;
    logic [2:0][CoordW-1:0]        p;
  } front_t;

endpackage

// File: design/ptp_if.sv
// Handshake channels of the projection core: input items, result items, config.
// Depends on nothing.
interface ptp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x, a_y, a_z;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] c_x, c_y, c_z;
  logic signed [31:0] point_x, point_y, point_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                point_x, point_y, point_z, output ready);
endinterface

interface ptp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] proj_x, proj_y, proj_z;
  logic               inside_res;
  logic               degenerate;
  modport source (output valid, proj_x, proj_y, proj_z, inside_res, degenerate,
                  input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, inside_res, degenerate,
                output ready);
endinterface

interface ptp_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

// File: design/ptp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; used by the projection core top level.
module ptp_div #(
  parameter int unsigned NumW  = 96,
  parameter int unsigned DenW  = 61,
  parameter int unsigned QuoW  = 43,
  parameter int unsigned SideW = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic             ovf_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned HiW  = NumW - QuoW;
  localparam int unsigned CmpW = (HiW > DenW) ? HiW : DenW;

  logic [CmpW-1:0]  hi_ext, den_ext;
  logic             ovf_d;
  logic [DenW-1:0]  rem_d;

  logic [QuoW:0]    vld_q;
  logic [DenW-1:0]  rem_q  [QuoW+1];
  logic [QuoW-1:0]  sh_q   [QuoW+1];
  logic [DenW-1:0]  den_q  [QuoW+1];
  logic             ovf_q  [QuoW+1];
  logic [SideW-1:0] side_q [QuoW+1];

  assign hi_ext  = CmpW'(num_i[NumW-1:QuoW]);
  assign den_ext = CmpW'(den_i);
  assign ovf_d   = hi_ext >= den_ext;
  assign rem_d   = ovf_d ? '0 : DenW'(hi_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d;
      sh_q[0]   <= num_i[QuoW-1:0];
      den_q[0]  <= den_i;
      ovf_q[0]  <= ovf_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_stage
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;
    assign trial = {rem_q[k-1], sh_q[k-1][QuoW-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        sh_q[k]   <= {sh_q[k-1][QuoW-2:0], ge};
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QuoW];
  assign quo_o   = sh_q[QuoW];
  assign ovf_o   = ovf_q[QuoW];
  assign side_o  = side_q[QuoW];

endmodule

// File: design/ptp_front.sv
// Front pipeline: edge vectors, block scaling, normal, dot products, divider operands.
// Depends on ptp_pkg.
module ptp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][31:0]     a_i,
  input  logic [2:0][31:0]     b_i,
  input  logic [2:0][31:0]     c_i,
  input  logic [2:0][31:0]     p_i,
  output logic                 valid_o,
  output ptp_pkg::front_t      res_o
);

  function automatic logic [31:0] fold33(input logic signed [32:0] v);
    return v[32] ? ~v[31:0] : v[31:0];
  endfunction

  function automatic logic [29:0] fold31(input logic signed [30:0] v);
    return v[30] ? ~v[29:0] : v[29:0];
  endfunction

  // smallest right shift that brings the magnitude below 2^14
  function automatic logic [4:0] blk_k(input logic [31:0] m);
    logic [4:0] k;
    k = '0;
    for (int i = 14; i < 32; i++) begin
      if (m[i]) k = 5'(i - 13);
    end
    return k;
  endfunction

  logic [6:0] vld_q;

  // stage 1
  logic signed [32:0] e1_q [3], e2_q [3], d_q [3];
  logic [2:0][31:0]   p1_q;
  // stage 2
  logic [31:0]        fe_d, fd_d;
  logic [4:0]         ke_d, kd_d;
  logic signed [14:0] f1_d [3], f2_d [3], g_d [3];
  logic signed [14:0] f1_q [3], f2_q [3], g2_q [3];
  logic [4:0]         ke2_q, kd2_q;
  logic signed [65:0] pr_q [6];
  logic [2:0][31:0]   p2_q;
  // stage 3
  logic signed [30:0] n3_q [3], t1_q [3], t2_q [3];
  logic signed [14:0] g3_q [3];
  logic               dx3_q;
  logic [4:0]         ke3_q, kd3_q;
  logic [2:0][31:0]   p3_q;
  // stage 4
  logic signed [61:0] nn_s, rn_s, sn_s;
  logic [4:0]         kn_d;
  logic signed [14:0] h_d [3];
  logic [60:0]        nn4_q;
  logic signed [61:0] rn4_q, sn4_q;
  logic signed [14:0] h4_q [3], g4_q [3];
  logic [4:0]         ke4_q, kd4_q;
  logic               dg4_q;
  logic [2:0][31:0]   p4_q;
  // stage 5
  logic signed [31:0] m2_s, dn_s;
  logic [30:0]        m2_5_q;
  logic signed [30:0] dn5_q;
  logic [5:0]         sh5_q;
  logic [59:0]        rm5_q, sm5_q;
  logic               rneg5_q, sneg5_q;
  logic signed [14:0] h5_q [3];
  logic [60:0]        nn5_q;
  logic [4:0]         kd5_q;
  logic               dg5_q;
  logic [2:0][31:0]   p5_q;
  // stage 6
  logic signed [45:0] x6_q [3];
  logic [59:0]        rm6_q, sm6_q;
  logic [5:0]         sh6_q;
  logic               rneg6_q, sneg6_q;
  logic [30:0]        m2_6_q;
  logic [60:0]        nn6_q;
  logic [4:0]         kd6_q;
  logic               dg6_q;
  logic [2:0][31:0]   p6_q;
  // stage 7
  ptp_pkg::front_t    res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= $signed({b_i[i][31], b_i[i]}) - $signed({a_i[i][31], a_i[i]});
        e2_q[i] <= $signed({c_i[i][31], c_i[i]}) - $signed({a_i[i][31], a_i[i]});
        d_q[i]  <= $signed({p_i[i][31], p_i[i]}) - $signed({a_i[i][31], a_i[i]});
      end
      p1_q <= p_i;
    end
  end

  always_comb begin
    fe_d = '0;
    fd_d = '0;
    for (int i = 0; i < 3; i++) begin
      fe_d = fe_d | fold33(e1_q[i]) | fold33(e2_q[i]);
      fd_d = fd_d | fold33(d_q[i]);
    end
    ke_d = blk_k(fe_d);
    kd_d = blk_k(fd_d);
    for (int i = 0; i < 3; i++) begin
      f1_d[i] = 15'(e1_q[i] >>> ke_d);
      f2_d[i] = 15'(e2_q[i] >>> ke_d);
      g_d[i]  = 15'(d_q[i] >>> kd_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q  <= f1_d;
      f2_q  <= f2_d;
      g2_q  <= g_d;
      ke2_q <= ke_d;
      kd2_q <= kd_d;
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
      p2_q  <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n3_q[0]  <= f1_q[1] * f2_q[2] - f1_q[2] * f2_q[1];
      n3_q[1]  <= f1_q[2] * f2_q[0] - f1_q[0] * f2_q[2];
      n3_q[2]  <= f1_q[0] * f2_q[1] - f1_q[1] * f2_q[0];
      t1_q[0]  <= g2_q[1] * f2_q[2] - g2_q[2] * f2_q[1];
      t1_q[1]  <= g2_q[2] * f2_q[0] - g2_q[0] * f2_q[2];
      t1_q[2]  <= g2_q[0] * f2_q[1] - g2_q[1] * f2_q[0];
      t2_q[0]  <= f1_q[1] * g2_q[2] - f1_q[2] * g2_q[1];
      t2_q[1]  <= f1_q[2] * g2_q[0] - f1_q[0] * g2_q[2];
      t2_q[2]  <= f1_q[0] * g2_q[1] - f1_q[1] * g2_q[0];
      dx3_q    <= (pr_q[0] == pr_q[1]) && (pr_q[2] == pr_q[3]) && (pr_q[4] == pr_q[5]);
      g3_q     <= g2_q;
      ke3_q    <= ke2_q;
      kd3_q    <= kd2_q;
      p3_q     <= p2_q;
    end
  end

  always_comb begin
    nn_s = n3_q[0] * n3_q[0] + n3_q[1] * n3_q[1] + n3_q[2] * n3_q[2];
    rn_s = n3_q[0] * t1_q[0] + n3_q[1] * t1_q[1] + n3_q[2] * t1_q[2];
    sn_s = n3_q[0] * t2_q[0] + n3_q[1] * t2_q[1] + n3_q[2] * t2_q[2];
    kn_d = blk_k({2'b00, fold31(n3_q[0]) | fold31(n3_q[1]) | fold31(n3_q[2])});
    for (int i = 0; i < 3; i++) begin
      h_d[i] = 15'(n3_q[i] >>> kn_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn4_q <= nn_s[60:0];
      rn4_q <= rn_s;
      sn4_q <= sn_s;
      h4_q  <= h_d;
      g4_q  <= g3_q;
      ke4_q <= ke3_q;
      kd4_q <= kd3_q;
      dg4_q <= dx3_q || (n3_q[0] == '0 && n3_q[1] == '0 && n3_q[2] == '0);
      p4_q  <= p3_q;
    end
  end

  always_comb begin
    m2_s = h4_q[0] * h4_q[0] + h4_q[1] * h4_q[1] + h4_q[2] * h4_q[2];
    dn_s = g4_q[0] * h4_q[0] + g4_q[1] * h4_q[1] + g4_q[2] * h4_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_5_q  <= m2_s[30:0];
      dn5_q   <= dn_s[30:0];
      sh5_q   <= 6'd18 + {1'b0, kd4_q} - {1'b0, ke4_q};
      rm5_q   <= rn4_q[61] ? 60'(-rn4_q) : 60'(rn4_q);
      sm5_q   <= sn4_q[61] ? 60'(-sn4_q) : 60'(sn4_q);
      rneg5_q <= rn4_q[61];
      sneg5_q <= sn4_q[61];
      h5_q    <= h4_q;
      nn5_q   <= nn4_q;
      kd5_q   <= kd4_q;
      dg5_q   <= dg4_q;
      p5_q    <= p4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        x6_q[i] <= h5_q[i] * dn5_q;
      end
      rm6_q   <= rm5_q;
      sm6_q   <= sm5_q;
      sh6_q   <= sh5_q;
      rneg6_q <= rneg5_q;
      sneg6_q <= sneg5_q;
      m2_6_q  <= m2_5_q;
      nn6_q   <= nn5_q;
      kd6_q   <= kd5_q;
      dg6_q   <= dg5_q;
      p6_q    <= p5_q;
    end
  end

  always_comb begin
    res_d.degen = dg6_q;
    res_d.r_neg = rneg6_q;
    res_d.s_neg = sneg6_q;
    res_d.r_num = ptp_pkg::RsNumW'(rm6_q) << sh6_q;
    res_d.s_num = ptp_pkg::RsNumW'(sm6_q) << sh6_q;
    res_d.nn    = nn6_q;
    res_d.m2    = m2_6_q;
    res_d.p     = p6_q;
    for (int i = 0; i < 3; i++) begin
      res_d.d_neg[i] = x6_q[i][45];
      res_d.d_num[i] = ptp_pkg::DpNumW'(x6_q[i][45] ? 44'(-x6_q[i]) : 44'(x6_q[i])) << kd6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[6];
  assign res_o   = res_q;

endmodule

// File: design/point_triangle_projection_core.sv
// Point to triangle plane projection with inside test: top level.
// Depends on ptp_pkg, ptp_if, ptp_front and ptp_div.
//
// Takes one item per clock and returns one result per item, in order. An item
// passes through seven front stages (edge vectors, block scaling, normal,
// dot products, operand alignment), 44 stages of the bit-per-stage dividers
// that form r, s and the three displacements side by side, and the output
// register. Back-pressure on the result channel freezes the whole pipeline;
// no item is dropped or repeated. The tolerance register is written through
// its own channel, which is always ready.
module point_triangle_projection_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o,
  ptp_cfg_if.sink   cfg_i
);

  localparam int unsigned QW = ptp_pkg::QuoW;

  logic                        en;
  logic [ptp_pkg::TolW-1:0]    tol_q;
  logic [2:0][31:0]            a_v, b_v, c_v, p_v;
  logic                        fr_vld;
  ptp_pkg::front_t             fr;

  logic                        r_vld, s_vld;
  logic [QW-1:0]               r_quo, s_quo;
  logic                        r_ovf, s_ovf;
  logic [1:0]                  r_side;
  logic                        s_side;
  logic [2:0]                  d_vld, d_ovf;
  logic [QW-1:0]               d_quo [3];
  logic [32:0]                 d_side [3];

  logic [ptp_pkg::RsW-2:0]     r_mag, s_mag;
  logic signed [ptp_pkg::RsW+1:0] r_e, s_e, tol_e;
  logic                        ins_d;
  logic signed [44:0]          diff;
  logic [2:0][31:0]            proj_d;

  logic                        out_vld_q;
  logic [2:0][31:0]            proj_q;
  logic                        ins_q, dg_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ptp_pkg::TolReset;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  assign a_v = {in_i.a_z, in_i.a_y, in_i.a_x};
  assign b_v = {in_i.b_z, in_i.b_y, in_i.b_x};
  assign c_v = {in_i.c_z, in_i.c_y, in_i.c_x};
  assign p_v = {in_i.point_z, in_i.point_y, in_i.point_x};

  ptp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .a_i     (a_v),
    .b_i     (b_v),
    .c_i     (c_v),
    .p_i     (p_v),
    .valid_o (fr_vld),
    .res_o   (fr)
  );

  ptp_div #(
    .NumW (ptp_pkg::RsNumW),
    .DenW (ptp_pkg::RsDenW),
    .QuoW (QW),
    .SideW(2)
  ) u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .num_i   (fr.r_num),
    .den_i   (fr.nn),
    .side_i  ({fr.degen, fr.r_neg}),
    .valid_o (r_vld),
    .quo_o   (r_quo),
    .ovf_o   (r_ovf),
    .side_o  (r_side)
  );

  ptp_div #(
    .NumW (ptp_pkg::RsNumW),
    .DenW (ptp_pkg::RsDenW),
    .QuoW (QW),
    .SideW(1)
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .num_i   (fr.s_num),
    .den_i   (fr.nn),
    .side_i  (fr.s_neg),
    .valid_o (s_vld),
    .quo_o   (s_quo),
    .ovf_o   (s_ovf),
    .side_o  (s_side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_disp
    ptp_div #(
      .NumW (ptp_pkg::DpNumW),
      .DenW (ptp_pkg::DpDenW),
      .QuoW (QW),
      .SideW(33)
    ) u_div_d (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (fr_vld),
      .num_i   (fr.d_num[i]),
      .den_i   (fr.m2),
      .side_i  ({fr.d_neg[i], fr.p[i]}),
      .valid_o (d_vld[i]),
      .quo_o   (d_quo[i]),
      .ovf_o   (d_ovf[i]),
      .side_o  (d_side[i])
    );
  end

  always_comb begin
    r_mag = (r_ovf || (r_quo[QW-1:2] > ptp_pkg::RsLim)) ? ptp_pkg::RsLim : r_quo[QW-1:2];
    s_mag = (s_ovf || (s_quo[QW-1:2] > ptp_pkg::RsLim)) ? ptp_pkg::RsLim : s_quo[QW-1:2];
    r_e   = r_side[0] ? -$signed({3'b000, r_mag}) : $signed({3'b000, r_mag});
    s_e   = s_side ? -$signed({3'b000, s_mag}) : $signed({3'b000, s_mag});
    tol_e = $signed({27'd0, tol_q});
    ins_d = !r_side[1] && (r_e >= -tol_e) && (s_e >= -tol_e) &&
            (r_e + s_e <= ptp_pkg::OneQ + tol_e);
    diff  = '0;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({{13{d_side[i][31]}}, d_side[i][31:0]}) -
             (d_side[i][32] ? -$signed({2'b00, d_quo[i]}) : $signed({2'b00, d_quo[i]}));
      if (r_side[1]) begin
        proj_d[i] = d_side[i][31:0];
      end else if (d_ovf[i]) begin
        proj_d[i] = d_side[i][32] ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (diff[44:31] == {14{diff[31]}}) begin
        proj_d[i] = diff[31:0];
      end else begin
        proj_d[i] = diff[44] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r_vld && s_vld && (&d_vld);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      proj_q <= proj_d;
      ins_q  <= ins_d;
      dg_q   <= r_side[1];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.proj_x     = proj_q[0];
  assign out_o.proj_y     = proj_q[1];
  assign out_o.proj_z     = proj_q[2];
  assign out_o.inside_res = ins_q;
  assign out_o.degenerate = dg_q;

endmodule
